/* design/nearest_three_distance_interpolator_top_defines.svh */
// ----------------------------------------------------------------------------
// Nearest-three interpolator assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_THREE_DISTANCE_INTERPOLATOR_TOP_DEFINES_SVH
`define NEAREST_THREE_DISTANCE_INTERPOLATOR_TOP_DEFINES_SVH
// implication checked on every clock outside reset
`define N3I_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("n3i check failed");
// next-cycle implication
`define N3I_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("n3i check failed");
`endif

/* design/n3i_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest-three interpolator package
// Shared types and constants.
// ----------------------------------------------------------------------------
`default_nettype none
package n3i_pkg;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SAMP  = 2'd1;
  localparam logic [1:0] ST_ZERO_SUM = 2'd2;
  localparam logic [32:0] SQ_MAX = {33{1'b1}};

  // request handed from front to back end
  typedef struct packed {
    logic [1:0]        cnt;
    logic [2:0][32:0]  sq;
    logic [2:0][31:0]  val;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SQRT, BK_MUL, BK_ACC, BK_DIV, BK_FIN, BK_OUT
  } bk_state_t;
endpackage
`default_nettype wire

/* design/n3i_front.sv */
// ----------------------------------------------------------------------------
// Nearest-three interpolator front end
// Distance computation and sorted top-three insertion per request.
// ----------------------------------------------------------------------------
`default_nettype none
module n3i_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [79:0]        in_tdata,
  input  wire logic               in_tlast,
  input  wire logic               in_tuser,
  output logic                    job_valid,
  input  wire logic               job_ready,
  output n3i_pkg::job_t           job
);
  logic [2:0][15:0] q_r, q_nxt;
  logic [2:0][32:0] sq_r, sq_nxt;
  logic [2:0][31:0] val_r, val_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             jv_r, jv_nxt;
  n3i_pkg::job_t    job_r, job_nxt;
  logic [2:0][16:0] diff;
  logic [2:0][15:0] mag;
  logic [2:0][33:0] mag2;
  logic [35:0]      sum;
  logic [32:0]      sq;
  logic             acc;
  logic [1:0]       pos;
  logic             ins;

  assign in_tready = !jv_r || job_ready;
  assign acc = in_tvalid && in_tready;
  assign job_valid = jv_r;
  assign job = job_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = {in_tdata[16*a+15], in_tdata[16*a +: 16]} - {q_r[a][15], q_r[a]};
      mag[a] = diff[a][16] ? 16'(-diff[a]) : diff[a][15:0];
      mag2[a] = 34'({16'b0, mag[a]} * {16'b0, mag[a]});
    end
    sum = {2'b0, mag2[0]} + {2'b0, mag2[1]} + {2'b0, mag2[2]};
    sq = (sum > {3'b0, n3i_pkg::SQ_MAX}) ? n3i_pkg::SQ_MAX : sum[32:0];
    priority if (cnt_r > 2'd0 && sq < sq_r[0]) pos = 2'd0;
    else if (cnt_r > 2'd1 && sq < sq_r[1]) pos = 2'd1;
    else if (cnt_r > 2'd2 && sq < sq_r[2]) pos = 2'd2;
    else pos = cnt_r;
    ins = (pos != 2'd3);
  end

  always_comb begin
    q_nxt = q_r; sq_nxt = sq_r; val_nxt = val_r; cnt_nxt = cnt_r;
    jv_nxt = jv_r && !job_ready; job_nxt = job_r;
    if (acc) begin
      if (!in_tuser) begin
        for (int a = 0; a < 3; a++) q_nxt[a] = in_tdata[16*a +: 16];
        sq_nxt = {3{n3i_pkg::SQ_MAX}}; val_nxt = '0; cnt_nxt = 2'd0;
      end else if (ins) begin
        for (int i = 2; i > 0; i--)
          if (i > pos) begin
            sq_nxt[i] = sq_r[i-1]; val_nxt[i] = val_r[i-1];
          end
        sq_nxt[pos] = sq;
        val_nxt[pos] = in_tdata[79:48];
        if (cnt_r != 2'd3) cnt_nxt = cnt_r + 2'd1;
      end
      if (in_tlast) begin
        job_nxt.cnt = cnt_nxt; job_nxt.sq = sq_nxt; job_nxt.val = val_nxt;
        jv_nxt = 1'b1;
        sq_nxt = {3{n3i_pkg::SQ_MAX}}; val_nxt = '0; cnt_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0; sq_r <= {3{n3i_pkg::SQ_MAX}}; val_r <= '0; cnt_r <= '0; jv_r <= 1'b0;
    end else begin
      q_r <= q_nxt; sq_r <= sq_nxt; val_r <= val_nxt; cnt_r <= cnt_nxt; jv_r <= jv_nxt;
    end
    job_r <= job_nxt;
  end
endmodule
`default_nettype wire

/* design/n3i_back.sv */
// ----------------------------------------------------------------------------
// Nearest-three interpolator back end
// Serial roots, weights and restoring division for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module n3i_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               job_valid,
  output logic                    job_ready,
  input  n3i_pkg::job_t           job,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [39:0]             out_tdata
);
  n3i_pkg::bk_state_t st_r, st_nxt;
  n3i_pkg::job_t   j_r, j_nxt;
  logic [1:0]      ix_r, ix_nxt;
  logic [5:0]      k_r, k_nxt;
  logic [2:0][16:0] d_r, d_nxt;
  logic [33:0]     rem_r, rem_nxt;
  logic [16:0]     root_r, root_nxt;
  logic [2:0][33:0] w_r, w_nxt;
  logic [35:0]     ws_r, ws_nxt;
  logic [85:0]     num_r, num_nxt;
  logic [35:0]     pr_r, pr_nxt;
  logic [49:0]     quo_r, quo_nxt;
  logic [31:0]     res_r, res_nxt;
  logic [1:0]      sts_r, sts_nxt;
  logic [33:0]     sqx;
  logic [1:0]      pair;
  logic [35:0]     trial;
  logic [16:0]     ma, mb;
  logic [33:0]     prod;
  logic [65:0]     term;
  logic [36:0]     sh;
  logic [31:0]     qv;

  assign job_ready = (st_r == n3i_pkg::BK_IDLE);
  assign out_tdata = {6'b0, sts_r, res_r};

  always_comb begin
    sqx = {1'b0, j_r.sq[ix_r]};
    pair = sqx[6'd32 - {k_r[4:0], 1'b0} +: 2];
    trial = {rem_r, pair} - {1'b0, root_r, 2'b01} ;
    unique case (ix_r)
      2'd0: begin ma = d_r[1]; mb = d_r[2]; end
      2'd1: begin ma = d_r[2]; mb = d_r[0]; end
      default: begin ma = d_r[0]; mb = d_r[1]; end
    endcase
    prod = 34'({17'b0, ma} * {17'b0, mb});
    term = 66'(w_r[ix_r] * {34'b0, j_r.val[ix_r] ^ 32'h8000_0000});
    sh = {pr_r, num_r[85]};
    qv = quo_r[31:0] ^ 32'h8000_0000;
  end

  always_comb begin
    st_nxt = st_r; j_nxt = j_r; ix_nxt = ix_r; k_nxt = k_r; d_nxt = d_r;
    rem_nxt = rem_r; root_nxt = root_r; w_nxt = w_r; ws_nxt = ws_r;
    num_nxt = num_r; pr_nxt = pr_r; quo_nxt = quo_r; res_nxt = res_r; sts_nxt = sts_r;
    unique case (st_r)
      n3i_pkg::BK_IDLE: if (job_valid) begin
        j_nxt = job; res_nxt = '0; sts_nxt = n3i_pkg::ST_OK;
        ix_nxt = '0; k_nxt = '0; rem_nxt = '0; root_nxt = '0;
        if (job.cnt == 2'd0) begin
          sts_nxt = n3i_pkg::ST_NO_SAMP; st_nxt = n3i_pkg::BK_OUT;
        end else if (job.cnt == 2'd1) begin
          res_nxt = job.val[0]; st_nxt = n3i_pkg::BK_OUT;
        end else st_nxt = n3i_pkg::BK_SQRT;
      end
      n3i_pkg::BK_SQRT: begin
        // one root bit per cycle, 17 bits per distance (top pair is 1 bit)
        if (!trial[35] && trial[34:0] < 35'h4_0000_0000) begin
          rem_nxt = trial[33:0]; root_nxt = {root_r[15:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], pair};
          root_nxt = {root_r[15:0], 1'b0};
        end
        k_nxt = k_r + 6'd1;
        if (k_r == 6'd16) begin
          d_nxt[ix_r] = root_nxt; k_nxt = '0; rem_nxt = '0; root_nxt = '0;
          if (ix_r == 2'd2) begin
            ix_nxt = '0; st_nxt = n3i_pkg::BK_MUL;
          end else ix_nxt = ix_r + 2'd1;
        end
      end
      n3i_pkg::BK_MUL: begin
        if (j_r.cnt == 2'd2) begin
          w_nxt[0] = {17'b0, d_r[1]}; w_nxt[1] = {17'b0, d_r[0]}; w_nxt[2] = '0;
          ix_nxt = 2'd2;
        end else w_nxt[ix_r] = prod;
        ix_nxt = (ix_nxt == 2'd2) ? 2'd0 : ix_r + 2'd1;
        if (j_r.cnt == 2'd2 || ix_r == 2'd2) begin
          st_nxt = n3i_pkg::BK_ACC; ix_nxt = '0; num_nxt = '0;
        end
      end
      n3i_pkg::BK_ACC: begin
        num_nxt = num_r + {20'b0, term};
        ix_nxt = ix_r + 2'd1;
        if (ix_r == 2'd2) begin
          ws_nxt = {2'b0, w_r[0]} + {2'b0, w_r[1]} + {2'b0, w_r[2]};
          pr_nxt = '0; quo_nxt = '0; k_nxt = '0;
          if (ws_nxt == '0) begin
            sts_nxt = n3i_pkg::ST_ZERO_SUM; st_nxt = n3i_pkg::BK_OUT;
          end else st_nxt = n3i_pkg::BK_DIV;
        end
      end
      n3i_pkg::BK_DIV: begin
        // restoring division, one quotient bit per cycle over 86 bits
        num_nxt = {num_r[84:0], 1'b0};
        if (sh >= {1'b0, ws_r}) begin
          pr_nxt = 36'(sh - {1'b0, ws_r}); quo_nxt = {quo_r[48:0], 1'b1};
        end else begin
          pr_nxt = sh[35:0]; quo_nxt = {quo_r[48:0], 1'b0};
        end
        k_nxt = k_r + 6'd1;
        if (k_r == 6'd63) st_nxt = n3i_pkg::BK_FIN;
      end
      n3i_pkg::BK_FIN: begin
        num_nxt = {num_r[84:0], 1'b0};
        if (sh >= {1'b0, ws_r}) begin
          pr_nxt = 36'(sh - {1'b0, ws_r}); quo_nxt = {quo_r[48:0], 1'b1};
        end else begin
          pr_nxt = sh[35:0]; quo_nxt = {quo_r[48:0], 1'b0};
        end
        k_nxt = k_r + 6'd1;
        if (k_r == 6'd21) begin
          res_nxt = qv;
          if (quo_nxt[49:31] == '0 && pr_nxt != '0) res_nxt = (quo_nxt[31:0] ^ 32'h8000_0000)
            + 32'd1;
          else res_nxt = quo_nxt[31:0] ^ 32'h8000_0000;
          st_nxt = n3i_pkg::BK_OUT;
        end
      end
      n3i_pkg::BK_OUT: if (out_tready) st_nxt = n3i_pkg::BK_IDLE;
      default: st_nxt = n3i_pkg::BK_IDLE;
    endcase
  end

  always_comb out_tvalid = (st_r == n3i_pkg::BK_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= n3i_pkg::BK_IDLE;
    else st_r <= st_nxt;
    j_r <= j_nxt; ix_r <= ix_nxt; k_r <= k_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
    root_r <= root_nxt; w_r <= w_nxt; ws_r <= ws_nxt; num_r <= num_nxt; pr_r <= pr_nxt;
    quo_r <= quo_nxt; res_r <= res_nxt; sts_r <= sts_nxt;
  end
endmodule
`default_nettype wire

/* design/nearest_three_distance_interpolator_top.sv */
// ----------------------------------------------------------------------------
// Nearest-three distance interpolator
// Inverse-distance interpolation over the three nearest samples.
// ----------------------------------------------------------------------------
// Query and sample requests are taken one per cycle; the front end keeps the
// three nearest samples. A last request hands a snapshot to the back end
// through a one-entry register. With two or more samples the back end spends
// 51 root steps, three weight steps (one with two samples), three accumulate
// steps and 86 division steps before it offers the result; with no or one
// sample it offers the result straight from its idle state. While a snapshot
// waits in the hand-off register for a busy back end, the front end holds off
// every request.
`default_nettype none
module nearest_three_distance_interpolator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,  // coord_x, coord_y, coord_z, sample_value
  input  wire logic        in_tlast,
  input  wire logic        in_tuser,  // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata  // result_value, status
);
  logic          job_valid, job_ready;
  n3i_pkg::job_t job;

  n3i_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .in_tuser, .job_valid, .job_ready, .job);
  n3i_back u_back (.clk, .rst_n, .job_valid, .job_ready, .job, .out_tvalid,
    .out_tready, .out_tdata);
endmodule
`default_nettype wire

/* design/n3i_checker.sv */
// ----------------------------------------------------------------------------
// Nearest-three interpolator checker
// Port-level checks bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_three_distance_interpolator_top_defines.svh"
module n3i_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);
  `N3I_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `N3I_ASSERT_IMP(a_status, out_tvalid, out_tdata[33:32] != 2'd3)
  `N3I_ASSERT_IMP(a_nosamp_zero, out_tvalid && out_tdata[33:32] != 2'd0, out_tdata[31:0] == '0)
  `N3I_ASSERT_IMP(a_pad, out_tvalid, out_tdata[39:34] == '0)
endmodule
bind nearest_three_distance_interpolator_top n3i_checker u_chk (.clk, .rst_n,
  .out_tvalid, .out_tready, .out_tdata);
`default_nettype wire
